// ===== src/dpf_pkg.sv =====
`default_nettype none

package dpf_pkg;

    localparam int DPF_VALUE_WIDTH = 40;
    localparam int MAX_RESULTS     = 11;
    localparam int COUNT_W         = $clog2(MAX_RESULTS + 1);

endpackage

`default_nettype wire

// ===== src/distinct_prime_factors_trial_unit.sv =====
// Steps: each trial or divide-out step is a divider start, VALUE_WIDTH quotient
// bits and a decision; a value of 0 or 1 is answered without any divide step.
// Throughput: one request at a time; s_tready is low from acceptance until the last
// result has been loaded into the output register. Set by the single iterative divider.
// Reset: rst_n asynchronous, active low; clears the sequencer and output valid.
`default_nettype none

module distinct_prime_factors_trial_unit
    import dpf_pkg::*;
#(
    parameter int VALUE_WIDTH = DPF_VALUE_WIDTH,
    localparam int TDATA_W    = ((VALUE_WIDTH + 7) / 8) * 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // value
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // prime_factor
    output logic                    m_tuser,   // no_factor
    output logic                    m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TSTART,
        S_TEST,
        S_DSTART,
        S_DIVOUT,
        S_TAIL,
        S_FLUSH
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] v_reg, v_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [VALUE_WIDTH-1:0] pend_factor_reg, pend_factor_next;
    logic                   pend_none_reg, pend_none_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_factor_reg, out_factor_next;
    logic                   out_none_reg, out_none_next;
    logic                   out_last_reg, out_last_next;

    logic                   div_start;
    logic                   div_busy;
    logic [VALUE_WIDTH-1:0] quo;
    logic [VALUE_WIDTH-1:0] rem;
    logic                   out_free;
    logic                   can_push;
    logic [VALUE_WIDTH-1:0] value;

    assign value     = s_tdata[VALUE_WIDTH-1:0];
    assign out_free  = !out_valid_reg || m_tready;
    assign can_push  = !pend_valid_reg || out_free;
    assign div_start = (state_reg == S_TSTART) || (state_reg == S_DSTART);

    dpf_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (v_reg),
        .divisor  (d_reg),
        .busy     (div_busy),
        .quotient (quo),
        .remainder(rem)
    );

    always_comb
    begin
        state_next       = state_reg;
        v_next           = v_reg;
        d_next           = d_reg;
        count_next       = count_reg;
        pend_valid_next  = pend_valid_reg;
        pend_factor_next = pend_factor_reg;
        pend_none_next   = pend_none_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_factor_next  = out_factor_reg;
        out_none_next    = out_none_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    v_next          = value;
                    d_next          = VALUE_WIDTH'(2);
                    count_next      = '0;
                    pend_valid_next = 1'b0;
                    if (value <= VALUE_WIDTH'(1))
                    begin
                        pend_valid_next  = 1'b1;
                        pend_factor_next = '0;
                        pend_none_next   = 1'b1;
                        state_next       = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_TSTART;
                    end
                end
            end
            S_TSTART:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (!div_busy)
                begin
                    if (d_reg > quo)
                    begin
                        state_next = S_TAIL;
                    end
                    else if (rem != '0)
                    begin
                        d_next     = d_reg + VALUE_WIDTH'(1);
                        state_next = S_TSTART;
                    end
                    else if (can_push)
                    begin
                        // new factor: older pending one goes out, not last
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_factor_next = pend_factor_reg;
                            out_none_next   = pend_none_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_factor_next = d_reg;
                        pend_none_next   = 1'b0;
                        count_next       = count_reg + COUNT_W'(1);
                        v_next           = quo;
                        if (count_reg + COUNT_W'(1) == COUNT_W'(MAX_RESULTS))
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            state_next = S_DSTART;
                        end
                    end
                end
            end
            S_DSTART:
            begin
                state_next = S_DIVOUT;
            end
            S_DIVOUT:
            begin
                if (!div_busy)
                begin
                    if (rem == '0)
                    begin
                        v_next     = quo;
                        state_next = S_DSTART;
                    end
                    else
                    begin
                        d_next     = d_reg + VALUE_WIDTH'(1);
                        state_next = S_TSTART;
                    end
                end
            end
            S_TAIL:
            begin
                if (v_reg == VALUE_WIDTH'(1))
                begin
                    state_next = S_FLUSH;
                end
                else if (can_push)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_factor_next = pend_factor_reg;
                        out_none_next   = pend_none_reg;
                        out_last_next   = 1'b0;
                    end
                    pend_valid_next  = 1'b1;
                    pend_factor_next = v_reg;
                    pend_none_next   = 1'b0;
                    count_next       = count_reg + COUNT_W'(1);
                    state_next       = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_factor_next = pend_factor_reg;
                    out_none_next   = pend_none_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            v_reg           <= '0;
            d_reg           <= '0;
            count_reg       <= '0;
            pend_valid_reg  <= 1'b0;
            pend_factor_reg <= '0;
            pend_none_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_factor_reg  <= '0;
            out_none_reg    <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            v_reg           <= v_next;
            d_reg           <= d_next;
            count_reg       <= count_next;
            pend_valid_reg  <= pend_valid_next;
            pend_factor_reg <= pend_factor_next;
            pend_none_reg   <= pend_none_next;
            out_valid_reg   <= out_valid_next;
            out_factor_reg  <= out_factor_next;
            out_none_reg    <= out_none_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_factor_reg);
    assign m_tuser  = out_none_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_no_factor_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("no_factor result not a lone zero final result");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready again right after a request");

    a_flush_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> pend_valid_reg)
        else $error("flush without a pending result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_RESULTS))
        else $error("result count beyond limit");
`endif

endmodule

`default_nettype wire

// ===== src/dpf_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module dpf_div
    import dpf_pkg::*;
#(
    parameter int VALUE_WIDTH = DPF_VALUE_WIDTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [VALUE_WIDTH-1:0] divisor,
    output logic                        busy,
    output logic [VALUE_WIDTH-1:0]      quotient,
    output logic [VALUE_WIDTH-1:0]      remainder
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] div_reg, div_next;

    logic [VALUE_WIDTH:0]   shifted;
    logic                   fits;
    logic [VALUE_WIDTH-1:0] diff;

    assign shifted = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign fits    = (shifted >= {1'b0, div_reg});
    // exact whenever fits is set, as the difference is then below the divisor
    assign diff    = shifted[VALUE_WIDTH-1:0] - div_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_WIDTH);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!fits)
            begin
                rem_next = shifted[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff;
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire
